/* src/ptoe_pkg.sv */
// ----------------------------------------------------------------------------
// ptoe_pkg: shared types and helpers for the peer table
// Entry and request layouts, request and status codes, and the update merge.
// ----------------------------------------------------------------------------
package ptoe_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned OCC_W = 7;

  typedef enum logic [2:0] {
    RQ_SIGNAL = 3'd0,
    RQ_USER   = 3'd1,
    RQ_TELEM  = 3'd2,
    RQ_LOOKUP = 3'd3,
    RQ_REMOVE = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_EXIST   = 3'd0,
    ST_NEW     = 3'd1,
    ST_EVICT   = 3'd2,
    ST_MISS    = 3'd3,
    ST_REMOVED = 3'd4
  } status_e;

  typedef struct packed {
    logic [31:0]        key;
    logic [31:0]        heard;
    logic signed [8:0]  rssi;
    logic signed [15:0] snr;
    logic [7:0]         hops;
    logic [7:0]         battery;
    logic [7:0]         model;
    logic               user_known;
  } entry_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [31:0]        node_id;
    logic [31:0]        now_seconds;
    logic signed [8:0]  rssi_dbm;
    logic signed [15:0] snr_tenths;
    logic [7:0]         hop_count;
    logic [7:0]         model_code;
    logic [7:0]         batt_pct;
    logic               has_battery;
  } req_t;

  // Result of the shared compare unit.
  typedef struct packed {
    logic key_eq;
    logic heard_lt;
  } cmp_t;

  // Merges the fields of an update request into an entry and stamps the time.
  function automatic entry_t apply_update(entry_t ent, req_t rq);
    entry_t res;
    res = ent;
    case (rq.req_type)
      RQ_SIGNAL: begin
        res.rssi = rq.rssi_dbm;
        res.snr  = rq.snr_tenths;
        res.hops = rq.hop_count;
      end
      RQ_USER: begin
        res.model      = rq.model_code;
        res.user_known = 1'b1;
      end
      default: begin
        if (rq.has_battery) begin
          res.battery = rq.batt_pct;
        end
      end
    endcase
    res.heard = rq.now_seconds;
    return res;
  endfunction

endpackage

/* src/ptoe_cmp.sv */
// ----------------------------------------------------------------------------
// ptoe_cmp: shared compare unit
// Key equality for the search and last-heard ordering for the oldest scan.
// ----------------------------------------------------------------------------
module ptoe_cmp import ptoe_pkg::*; (
  input  logic [31:0] key_i,
  input  logic [31:0] heard_i,
  input  entry_t      entry_i,
  output cmp_t        cmp_o
);

  assign cmp_o.key_eq   = (entry_i.key == key_i);
  assign cmp_o.heard_lt = (entry_i.heard < heard_i);

endmodule

/* src/peer_table_oldest_eviction_core.sv */
// ----------------------------------------------------------------------------
// peer_table_oldest_eviction_core: neighbor table with oldest-entry reuse
// Keyed peer table with linear search, oldest scan and compacting remove.
// ----------------------------------------------------------------------------
// Each request is one transaction in and one transaction out. The block works
// on one request at a time and deasserts s_axis_tready until it is done. All
// entries live in a single-port-write, registered-read memory, so each entry
// visit takes an address state then a compare state. A search visits each
// valid entry in turn until it finds the key; an update that misses on a
// full table adds a scan of all 64 entries for the oldest one. A remove
// shifts each later valid entry down by one slot. A new request can be taken
// while the previous result still waits on the master side.
module peer_table_oldest_eviction_core import ptoe_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // node_id, now_seconds, rssi_dbm, snr_tenths, hop_count, model code,
  // battery percent, zero fill
  input  logic [119:0]  s_axis_tdata,
  // req_type, has_battery
  input  logic [3:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // slot, entry_node, entry_heard, entry_rssi, entry_snr, entry_hops,
  // entry_battery, entry_model, entry user-known flag, occupancy, evicted_node,
  // zero fill
  output logic [159:0]  m_axis_tdata,
  // status
  output logic [2:0]    m_axis_tuser
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_RD      = 11'b00000000010,
    S_CMP     = 11'b00000000100,
    S_HIT     = 11'b00000001000,
    S_MISS    = 11'b00000010000,
    S_MIN_RD  = 11'b00000100000,
    S_MIN_CMP = 11'b00001000000,
    S_EVICT   = 11'b00010000000,
    S_SH_RD   = 11'b00100000000,
    S_SH_WR   = 11'b01000000000,
    S_DONE    = 11'b10000000000
  } state_e;

  typedef struct packed {
    status_e           status;
    logic [IDX_W-1:0]  slot;
    entry_t            ent;
    logic [CNT_W-1:0]  occupancy;
    logic [31:0]       evicted;
  } result_t;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [IDX_W-1:0]  sh_q, sh_d;
  logic [CNT_W-1:0]  count_q, count_d;
  entry_t            ent_q, ent_d;
  logic [31:0]       min_heard_q, min_heard_d;
  logic [IDX_W-1:0]  min_idx_q, min_idx_d;
  logic [31:0]       min_key_q, min_key_d;
  result_t           stage_q, stage_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;

  entry_t            mem_q [TABLE_DEPTH];
  entry_t            rdata_q;
  logic [IDX_W-1:0]  raddr;
  logic              mem_we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;

  cmp_t              cmp;
  logic              is_update;
  entry_t            fresh;
  entry_t            merged;

  ptoe_cmp u_cmp (
    .key_i   (req_q.node_id),
    .heard_i (min_heard_q),
    .entry_i (rdata_q),
    .cmp_o   (cmp)
  );

  assign is_update = (req_q.req_type inside {RQ_SIGNAL, RQ_USER, RQ_TELEM});

  always_comb begin
    fresh     = '0;
    fresh.key = req_q.node_id;
  end

  assign merged = apply_update(fresh, req_q);

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    sh_d        = sh_q;
    count_d     = count_q;
    ent_d       = ent_q;
    min_heard_d = min_heard_q;
    min_idx_d   = min_idx_q;
    min_key_d   = min_key_q;
    stage_d     = stage_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    waddr       = slot_q;
    wdata       = merged;
    raddr       = idx_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_d.req_type      = s_axis_tuser[2:0];
          req_d.has_battery   = s_axis_tuser[3];
          req_d.node_id       = s_axis_tdata[31:0];
          req_d.now_seconds   = s_axis_tdata[63:32];
          req_d.rssi_dbm      = s_axis_tdata[72:64];
          req_d.snr_tenths    = s_axis_tdata[88:73];
          req_d.hop_count     = s_axis_tdata[96:89];
          req_d.model_code    = s_axis_tdata[104:97];
          req_d.batt_pct      = s_axis_tdata[112:105];
          idx_d   = '0;
          state_d = (count_q == '0) ? S_MISS : S_RD;
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (cmp.key_eq) begin
          ent_d   = rdata_q;
          slot_d  = idx_q;
          state_d = S_HIT;
        end else if (CNT_W'(idx_q) + CNT_W'(1) == count_q) begin
          state_d = S_MISS;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_RD;
        end
      end
      S_HIT: begin
        if (is_update) begin
          mem_we  = 1'b1;
          waddr   = slot_q;
          wdata   = apply_update(ent_q, req_q);
          stage_d = '{status: ST_EXIST, slot: slot_q, ent: wdata,
                      occupancy: count_q, evicted: '0};
          state_d = S_DONE;
        end else if (req_q.req_type == RQ_REMOVE) begin
          stage_d = '{status: ST_REMOVED, slot: slot_q, ent: ent_q,
                      occupancy: count_q - CNT_W'(1), evicted: '0};
          if (CNT_W'(slot_q) + CNT_W'(1) >= count_q) begin
            count_d = count_q - CNT_W'(1);
            state_d = S_DONE;
          end else begin
            sh_d    = slot_q;
            state_d = S_SH_RD;
          end
        end else begin
          stage_d = '{status: ST_EXIST, slot: slot_q, ent: ent_q,
                      occupancy: count_q, evicted: '0};
          state_d = S_DONE;
        end
      end
      S_MISS: begin
        if (!is_update) begin
          stage_d = '{status: ST_MISS, slot: '0, ent: '0,
                      occupancy: count_q, evicted: '0};
          state_d = S_DONE;
        end else if (count_q < CNT_W'(TABLE_DEPTH)) begin
          mem_we  = 1'b1;
          waddr   = IDX_W'(count_q);
          wdata   = merged;
          count_d = count_q + CNT_W'(1);
          stage_d = '{status: ST_NEW, slot: IDX_W'(count_q), ent: merged,
                      occupancy: count_q + CNT_W'(1), evicted: '0};
          state_d = S_DONE;
        end else begin
          idx_d   = '0;
          state_d = S_MIN_RD;
        end
      end
      S_MIN_RD: begin
        state_d = S_MIN_CMP;
      end
      S_MIN_CMP: begin
        // The first entry seeds the minimum; a tie keeps the lower index.
        if (idx_q == '0 || cmp.heard_lt) begin
          min_heard_d = rdata_q.heard;
          min_idx_d   = idx_q;
          min_key_d   = rdata_q.key;
        end
        if (idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
          state_d = S_EVICT;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_MIN_RD;
        end
      end
      S_EVICT: begin
        mem_we  = 1'b1;
        waddr   = min_idx_q;
        wdata   = merged;
        stage_d = '{status: ST_EVICT, slot: min_idx_q, ent: merged,
                    occupancy: count_q, evicted: min_key_q};
        state_d = S_DONE;
      end
      S_SH_RD: begin
        raddr   = sh_q + IDX_W'(1);
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        mem_we = 1'b1;
        waddr  = sh_q;
        wdata  = rdata_q;
        if (CNT_W'(sh_q) + CNT_W'(2) >= count_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_DONE;
        end else begin
          sh_d    = sh_q + IDX_W'(1);
          state_d = S_SH_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = stage_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    idx_q       <= idx_d;
    slot_q      <= slot_d;
    sh_q        <= sh_d;
    ent_q       <= ent_d;
    min_heard_q <= min_heard_d;
    min_idx_q   <= min_idx_d;
    min_key_q   <= min_key_d;
    stage_q     <= stage_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {1'b0,
                          out_q.evicted,
                          OCC_W'(out_q.occupancy),
                          out_q.ent.user_known,
                          out_q.ent.model,
                          out_q.ent.battery,
                          out_q.ent.hops,
                          out_q.ent.snr,
                          out_q.ent.rssi,
                          out_q.ent.heard,
                          out_q.ent.key,
                          SLOT_W'(out_q.slot)};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("occupancy exceeds the table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |->
      (count_q == $past(count_q) + CNT_W'(1) || count_q == $past(count_q) - CNT_W'(1)))
    else $error("occupancy moved by more than one");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SH_WR |-> CNT_W'(sh_q) + CNT_W'(1) < count_q)
    else $error("compaction wrote beyond the valid entries");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == ST_EVICT |-> out_q.occupancy == CNT_W'(TABLE_DEPTH))
    else $error("eviction reported on a table that is not full");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == ST_MISS |-> out_q.slot == '0 && out_q.evicted == '0)
    else $error("not-found result carries a slot or evicted key");

endmodule
